// ===== rtl/lsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrc_pkg
// shared types and constants of the lamp strike/restrike controller
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int TimerBitsDefault = 32;

  localparam logic [3:0] ST_OFF   = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_RUN   = 4'd2;
  localparam logic [3:0] ST_FPT   = 4'd3;
  localparam logic [3:0] ST_CD1   = 4'd4;
  localparam logic [3:0] ST_AT1   = 4'd5;
  localparam logic [3:0] ST_CD2   = 4'd6;
  localparam logic [3:0] ST_AT2   = 4'd7;
  localparam logic [3:0] ST_CD3   = 4'd8;
  localparam logic [3:0] ST_AT3   = 4'd9;
  localparam logic [3:0] ST_FAIL  = 4'd10;

  localparam logic [2:0] LVL_OFF     = 3'd0;
  localparam logic [2:0] LVL_FULL    = 3'd4;
  localparam logic [2:0] LVL_UNKNOWN = 3'd5;

  localparam logic [1:0] KIND_DIM    = 2'd1;
  localparam logic [1:0] KIND_NONDIM = 2'd2;

  localparam logic [2:0] REG_KIND      = 3'd0;
  localparam logic [2:0] REG_START_TO  = 3'd1;
  localparam logic [2:0] REG_COOLDOWN  = 3'd2;
  localparam logic [2:0] REG_FPT       = 3'd3;
  localparam logic [2:0] REG_NONDIM    = 3'd4;
  localparam logic [2:0] REG_DISCHARGE = 3'd5;

  localparam int InW  = 32;
  localparam int OutW = 56;

  typedef struct packed {
    logic [1:0]  lamp_kind;
    logic [15:0] start_timeout_ms;
    logic [15:0] cooldown_ms;
    logic [23:0] fullpower_test_ms;
    logic [15:0] nondim_check_ms;
    logic [9:0]  discharge_ms;
  } cfg_t;

  function automatic logic [6:0] duty_of(input logic [2:0] lvl);
    case (lvl)
      3'd1:    duty_of = 7'd100;
      3'd2:    duty_of = 7'd83;
      3'd3:    duty_of = 7'd50;
      default: duty_of = 7'd0;
    endcase
  endfunction

endpackage

// ===== rtl/lsrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lsrc_cfg_regs
// configuration register file
// ----------------------------------------------------------------------------
module lsrc_cfg_regs
  import lsrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lamp_kind         <= 2'd0;
      cfg_r.start_timeout_ms  <= 16'd10000;
      cfg_r.cooldown_ms       <= 16'd5000;
      cfg_r.fullpower_test_ms <= 24'd7200000;
      cfg_r.nondim_check_ms   <= 16'd1000;
      cfg_r.discharge_ms      <= 10'd100;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KIND:      cfg_r.lamp_kind         <= wr_data[1:0];
        REG_START_TO:  cfg_r.start_timeout_ms  <= wr_data[15:0];
        REG_COOLDOWN:  cfg_r.cooldown_ms       <= wr_data[15:0];
        REG_FPT:       cfg_r.fullpower_test_ms <= wr_data[23:0];
        REG_NONDIM:    cfg_r.nondim_check_ms   <= wr_data[15:0];
        REG_DISCHARGE: cfg_r.discharge_ms      <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lsrc_core.sv =====
// ----------------------------------------------------------------------------
// lsrc_core
// one-tick step: request handling, level inference, state machine, monitor
// ----------------------------------------------------------------------------
module lsrc_core
  import lsrc_pkg::*;
#(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  cfg_t            cfg,
  input  logic [InW-1:0]  in_item,
  output logic [OutW-1:0] out_item
);

  logic [3:0]            pend_r, pend_nxt;
  logic [2:0]            cons_r, cons_nxt;
  logic [2:0]            rep_r, rep_nxt;
  logic [3:0]            state_r, state_nxt;
  logic [2:0]            cmd_r;
  logic                  en_r, en_nxt;
  logic [TIMER_BITS-1:0] tmr_r, tmr_nxt, e;
  logic [1:0]            mon_r, mon_nxt;
  logic [9:0]            dis_r, dis_nxt;

  logic       req_valid, freq_valid, status_on, r12, r24, pok, roff_done, ron_busy;
  logic [2:0] req_level, lvl, cmd;
  logic [15:0] fhz;
  logic       consumed, rejected, rails_req, force_en, warming, go;
  logic [3:0] go_st;
  logic [31:0] elapsed;
  logic [63:0] tmr_wide;

  always_comb begin
    req_valid  = in_item[0];
    req_level  = in_item[3:1];
    freq_valid = in_item[4];
    fhz        = in_item[20:5];
    status_on  = in_item[21];
    r12        = in_item[22];
    r24        = in_item[23];
    pok        = in_item[24];
    roff_done  = in_item[25];
    ron_busy   = in_item[26];

    consumed = 1'b0; rejected = 1'b0; rails_req = 1'b0; force_en = 1'b0;
    state_nxt = state_r;
    tmr_nxt = (&tmr_r) ? tmr_r : tmr_r + 1'b1;
    pend_nxt = pend_r;
    cons_nxt = cons_r;
    rep_nxt = rep_r;
    mon_nxt = mon_r;
    dis_nxt = dis_r;

    if (req_valid) pend_nxt = (req_level <= 3'd4) ? {1'b1, req_level} : 4'd0;
    lvl = pend_nxt[2:0];
    if (pend_nxt[3] && lvl != cons_r && lvl != rep_r && state_r != ST_FAIL) begin
      if (cfg.lamp_kind == KIND_NONDIM && lvl != LVL_OFF && lvl != LVL_FULL) begin
        pend_nxt = 4'd0; rejected = 1'b1;
      end else if (lvl != LVL_OFF && (!r12 || !r24)) begin
        pend_nxt = 4'd0; rejected = 1'b1;
      end else begin
        if (rep_r == LVL_OFF && lvl != LVL_OFF) begin
          state_nxt = ST_START; tmr_nxt = '0;
        end
        cons_nxt = lvl; consumed = 1'b1;
      end
    end

    if (freq_valid) begin
      rep_nxt = LVL_UNKNOWN;
      if (cfg.lamp_kind == KIND_NONDIM) rep_nxt = (en_r && !status_on) ? LVL_FULL : LVL_OFF;
      else if (cmd_r == LVL_OFF) rep_nxt = LVL_OFF;
      else if (fhz < 16'd100) rep_nxt = status_on ? LVL_OFF : LVL_FULL;
      else if (fhz > 16'd900 && fhz < 16'd1100) rep_nxt = 3'd3;
      else if (fhz > 16'd400 && fhz < 16'd600) rep_nxt = 3'd2;
      else if (fhz > 16'd150 && fhz < 16'd250) rep_nxt = 3'd1;
    end

    e = tmr_nxt;
    cmd = LVL_OFF;
    go = 1'b0;
    go_st = state_nxt;
    case (state_nxt)
      ST_START: begin
        cmd = LVL_FULL;
        if (rep_nxt == LVL_FULL) begin go = 1'b1; go_st = ST_RUN; end
        if (e > TIMER_BITS'(cfg.start_timeout_ms)) begin go = 1'b1; go_st = ST_CD1; end
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
      end
      ST_RUN: begin
        cmd = cons_nxt;
        if (cfg.lamp_kind == KIND_DIM && e > TIMER_BITS'(cfg.fullpower_test_ms)) begin
          go = 1'b1; go_st = ST_FPT;
        end
        if (cfg.lamp_kind == KIND_NONDIM && e > TIMER_BITS'(cfg.nondim_check_ms)
            && rep_nxt != LVL_FULL) begin
          go = 1'b1; go_st = ST_CD1;
        end
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
      end
      ST_FPT: begin
        cmd = LVL_FULL;
        if (rep_nxt == LVL_FULL) begin go = 1'b1; go_st = ST_RUN; end
        else if (e > TIMER_BITS'(cfg.start_timeout_ms)) begin go = 1'b1; go_st = ST_CD1; end
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
      end
      ST_CD1, ST_CD2, ST_CD3: begin
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
        if (e > TIMER_BITS'(cfg.cooldown_ms)) begin go = 1'b1; go_st = state_nxt + 4'd1; end
      end
      ST_AT1, ST_AT2, ST_AT3: begin
        cmd = LVL_FULL;
        if (rep_nxt == LVL_FULL) begin go = 1'b1; go_st = ST_START; end
        if (e > TIMER_BITS'(cfg.start_timeout_ms)) begin go = 1'b1; go_st = state_nxt + 4'd1; end
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
      end
      ST_FAIL: begin
        if (cons_nxt == LVL_OFF) begin go = 1'b1; go_st = ST_OFF; end
      end
      default: ;
    endcase
    if (cmd > 3'd4) cmd = LVL_OFF;
    if (go) begin state_nxt = go_st; tmr_nxt = '0; end

    case (mon_r)
      2'd0: if (state_nxt != ST_OFF && !pok) begin
        force_en = 1'b1; dis_nxt = '0; mon_nxt = 2'd1;
      end
      2'd1: if (dis_r >= cfg.discharge_ms) begin
        rails_req = 1'b1; mon_nxt = 2'd2;
      end else begin
        dis_nxt = dis_r + 10'd1; force_en = 1'b1;
      end
      2'd2: if (roff_done && !ron_busy) begin
        state_nxt = ST_OFF; tmr_nxt = '0; mon_nxt = 2'd0;
      end
      default: mon_nxt = 2'd0;
    endcase
    en_nxt = (cmd != LVL_OFF) || force_en;

    warming = (state_nxt == ST_START) ||
              (state_nxt == ST_RUN && tmr_nxt < TIMER_BITS'(cfg.start_timeout_ms));
    tmr_wide = 64'(tmr_nxt);
    elapsed = (|tmr_wide[63:32]) ? '1 : tmr_wide[31:0];

    out_item = {2'd0, rejected, consumed, elapsed, rails_req, warming, rep_nxt,
                state_nxt, en_nxt, duty_of(cmd), cmd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= {1'b1, LVL_OFF}; cons_r <= LVL_OFF; rep_r <= LVL_UNKNOWN;
      state_r <= ST_OFF; cmd_r <= LVL_OFF; en_r <= 1'b0; tmr_r <= '0;
      mon_r <= 2'd0; dis_r <= '0;
    end else if (step) begin
      pend_r <= pend_nxt; cons_r <= cons_nxt; rep_r <= rep_nxt;
      state_r <= state_nxt; cmd_r <= cmd; en_r <= en_nxt; tmr_r <= tmr_nxt;
      mon_r <= mon_nxt; dis_r <= dis_nxt;
    end
  end

endmodule

// ===== rtl/lamp_strike_restrike_controller.sv =====
// ----------------------------------------------------------------------------
// lamp_strike_restrike_controller
// millisecond-tick lamp strike, restrike and emergency shutdown controller
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transfer per millisecond tick with request, frequency and
//           rail/status flags
//   out_* : one result per tick: command level, duty, enable, state and flags
//   cfg_* : register writes (index 0..5); the user makes them while the block is idle, unenforced
// output: the result of a tick is registered and appears in the cycle after its transfer
// throughput: one tick per cycle unless stalled; the state update is a single compare
//   and select pass between the state registers and the output register
// reset: registers take their default values, state off, level unknown
// stall: the output register holds its result while out_tready is low;
//   in_tready is high when the output register is empty or being taken
// ----------------------------------------------------------------------------
module lamp_strike_restrike_controller
  import lsrc_pkg::*;
#(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // req_valid, req_level, freq_valid, freq_hz, status_on, rail_12v_on,
  // rail_24v_on, power_ok, rails_off_done, rails_on_busy
  input  logic [InW-1:0]  in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // cmd_level, pwm_duty, lamp_enable, strike_state, reported_level, warming,
  // rails_off_request, elapsed_ms, req_consumed, req_rejected
  output logic [OutW-1:0] out_tdata,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  cfg_t            cfg;
  logic            step;
  logic [OutW-1:0] res;
  logic [OutW-1:0] out_data_r;
  logic            out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  lsrc_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  lsrc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .cfg(cfg), .in_item(in_tdata),
    .out_item(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
    if (step) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("accepted tick gave no result");
  a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[52] && out_tdata[53]))
    else $error("request both consumed and rejected");

endmodule
